// ----- rtl/char_lcd_i2c_nibble_sequencer_top_macros.svh -----
// assertion macros shared by the lcd sequencer rtl
// no dependencies; define ASSERT_OFF to drop every assertion
`ifndef CHAR_LCD_I2C_NIBBLE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_I2C_NIBBLE_SEQUENCER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/lcdseq_pkg.sv -----
// shared types, constants and helpers for the lcd nibble sequencer
// no dependencies
package lcdseq_pkg;

  localparam int VALUE_W        = 16;
  localparam int DIGIT_W        = 4;
  localparam int BYTE_W         = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_DIGITS_DEF = 5;
  localparam int ROW_COUNT      = 4;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] EN_MASK_RST   = 8'h04;
  localparam logic [7:0] RS_MASK_RST   = 8'h01;
  localparam logic [7:0] BL_MASK_RST   = 8'h08;

  // six expander beats per lcd byte
  localparam logic [2:0] BEAT_FIRST_LO = 3'd3;
  localparam logic [2:0] BEAT_LAST     = 3'd5;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_DATA   = 2'd1,
    OP_NUM    = 2'd2,
    OP_CURSOR = 2'd3
  } lcdseq_op_t;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_SELECT    = 2'd1,
    REG_BACKLIGHT = 2'd2
  } lcdseq_reg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
    logic [5:0]         col;
    logic [1:0]         row;
  } lcdseq_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] expander_byte;
    logic              last;
  } lcdseq_out_t;

  typedef struct packed {
    logic [BYTE_W-1:0] enable;
    logic [BYTE_W-1:0] select;
    logic [BYTE_W-1:0] backlight;
  } lcdseq_masks_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] lcd_byte;
    logic              is_data;
    logic              last_byte;
  } lcdseq_byte_req_t;

  // ddram start address of each display row
  function automatic logic [7:0] row_offset(input logic [1:0] r);
    logic [7:0] off;
    case (r)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/lcdseq_digit_conv.sv -----
// bit-serial binary to decimal converter (shift and add-3), one input bit per cycle
// depends on lcdseq_pkg
module lcdseq_digit_conv #(
  parameter int MAX_DIGITS = lcdseq_pkg::MAX_DIGITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic [lcdseq_pkg::VALUE_W-1:0]     value_i,
  output logic                               busy_o,
  output logic                               ovf_o,
  input  logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] rd_idx_i,
  output logic [lcdseq_pkg::DIGIT_W-1:0]     rd_digit_o
);

  localparam int CNT_W = $clog2(lcdseq_pkg::VALUE_W + 1);

  logic                           busy_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [lcdseq_pkg::VALUE_W-1:0] bin_r;
  logic                           ovf_r;
  logic [lcdseq_pkg::DIGIT_W-1:0] digit_r   [MAX_DIGITS];
  logic [lcdseq_pkg::DIGIT_W-1:0] adj       [MAX_DIGITS];
  logic [lcdseq_pkg::DIGIT_W-1:0] digit_nxt [MAX_DIGITS];

  // add 3 to every digit of 5 or more, then shift the whole bcd word left
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digit_r[i] >= 4'd5) ? digit_r[i] + 4'd3 : digit_r[i];
    end
    digit_nxt[0] = {adj[0][2:0], bin_r[lcdseq_pkg::VALUE_W-1]};
    for (int i = 1; i < MAX_DIGITS; i++) begin
      digit_nxt[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(lcdseq_pkg::VALUE_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // digits above the top one are dropped, leaving the value modulo ten to the depth;
  // ovf_r remembers that a carry left the top digit
  always_ff @(posedge clk) begin
    if (start_i) begin
      bin_r <= value_i;
      ovf_r <= 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit_r[i] <= '0;
      end
    end else if (busy_r) begin
      bin_r <= {bin_r[lcdseq_pkg::VALUE_W-2:0], 1'b0};
      ovf_r <= ovf_r | adj[MAX_DIGITS-1][3];
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit_r[i] <= digit_nxt[i];
      end
    end
  end

  assign busy_o     = busy_r;
  assign ovf_o      = ovf_r;
  assign rd_digit_o = digit_r[rd_idx_i];

endmodule

// ----- rtl/lcdseq_nibble_tx.sv -----
// splits one lcd byte into six expander beats and holds each until taken
// depends on lcdseq_pkg and the assertion macro header
`include "char_lcd_i2c_nibble_sequencer_top_macros.svh"

module lcdseq_nibble_tx (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lcdseq_pkg::lcdseq_masks_t    masks_i,
  input  lcdseq_pkg::lcdseq_byte_req_t req_i,
  output logic                         req_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lcdseq_pkg::lcdseq_out_t      out_data_o
);

  logic       busy_r;
  logic [2:0] beat_r;
  logic [7:0] byte_r;
  logic [7:0] mode_r;
  logic       last_r;
  logic [3:0] nib;
  logic [7:0] base;
  logic [7:0] xbyte;
  logic       load;
  logic       take;

  assign load = req_i.valid && !busy_r;
  assign take = busy_r && out_ready_i;

  // plain, enable high, enable low for each nibble
  always_comb begin
    nib  = (beat_r < lcdseq_pkg::BEAT_FIRST_LO) ? byte_r[7:4] : byte_r[3:0];
    base = {nib, 4'b0000} | mode_r;
    case (beat_r)
      3'd1, 3'd4: xbyte = base | masks_i.enable;
      3'd2, 3'd5: xbyte = base & ~masks_i.enable;
      default:    xbyte = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      beat_r <= '0;
    end else if (take) begin
      if (beat_r == lcdseq_pkg::BEAT_LAST) begin
        busy_r <= 1'b0;
        beat_r <= '0;
      end else begin
        beat_r <= beat_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= req_i.lcd_byte;
      mode_r <= masks_i.backlight | (req_i.is_data ? masks_i.select : 8'h00);
      last_r <= req_i.last_byte;
    end
  end

  assign req_ready_o              = !busy_r;
  assign out_valid_o              = busy_r;
  assign out_data_o.expander_byte = xbyte;
  assign out_data_o.last          = last_r && (beat_r == lcdseq_pkg::BEAT_LAST);

  `ASSERT_NEXT(a_load_starts_at_first_beat, clk, rst_n, load, busy_r && (beat_r == 3'd0))
  `ASSERT_IMPLY(a_idle_beat_zero, clk, rst_n, !busy_r, beat_r == 3'd0)

endmodule

// ----- rtl/char_lcd_i2c_nibble_sequencer_top.sv -----
// top level of the character-lcd nibble sequencer for an i2c port expander
// depends on lcdseq_pkg, lcdseq_digit_conv, lcdseq_nibble_tx and the macro header
`include "char_lcd_i2c_nibble_sequencer_top_macros.svh"

// Turns one request (command byte, data character, decimal number or set
// cursor) into the expander byte stream of a 4-bit HD44780 bus: every lcd byte
// goes out as high then low nibble, each nibble as three beats (plain, enable
// high, enable low). One request is handled at a time. A command, character or
// cursor request runs from its accept through ST_SEND, which hands the byte to
// the nibble sender, then the six output beats, then ST_WAIT until the sender
// is free, before in_ready rises again. A number request runs the bit-serial
// decimal converter over all 16 input bits (one input bit per cycle), then in
// ST_DIGITS skips each leading zero digit and hands each printed digit to the
// sender as one byte of six beats, with the same accept and closing steps
// around them; the six beats per lcd byte, one per cycle while out_ready is
// high, set the pace. A number longer than MAX_DIGITS prints its low
// MAX_DIGITS digits, zeros included. Configuration writes are always taken
// (cfg_ready is tied high) and must only happen while the block is idle; an
// index past the three mask registers is ignored.
module char_lcd_i2c_nibble_sequencer_top #(
  parameter int MAX_DIGITS = lcdseq_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lcdseq_pkg::lcdseq_in_t              in_data,
  // expander byte channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output lcdseq_pkg::lcdseq_out_t             out_data,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcdseq_pkg::BYTE_W-1:0]       cfg_data
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CONV   = 5'b00010,
    ST_DIGITS = 5'b00100,
    ST_SEND   = 5'b01000,
    ST_WAIT   = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;       // digit being looked at
  logic                         started_r, started_nxt;  // first nonzero digit seen
  logic [7:0]                   pend_byte_r, pend_byte_nxt;
  logic                         pend_data_r, pend_data_nxt;
  lcdseq_pkg::lcdseq_masks_t    masks_r;
  lcdseq_pkg::lcdseq_byte_req_t req;
  logic                         req_ready;
  logic                         conv_start;
  logic                         conv_busy;
  logic                         conv_ovf;
  logic [3:0]                   rd_digit;
  logic [1:0]                   row_cl;
  logic [7:0]                   cursor_byte;
  logic                         in_take;
  logic                         skip_zero;
  logic                         last_take;

  // mask registers, written one beat at a time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r.enable    <= lcdseq_pkg::EN_MASK_RST;
      masks_r.select    <= lcdseq_pkg::RS_MASK_RST;
      masks_r.backlight <= lcdseq_pkg::BL_MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcdseq_pkg::REG_ENABLE:    masks_r.enable    <= cfg_data;
        lcdseq_pkg::REG_SELECT:    masks_r.select    <= cfg_data;
        lcdseq_pkg::REG_BACKLIGHT: masks_r.backlight <= cfg_data;
        default: ;
      endcase
    end
  end

  // set-cursor address, rows past the last one clamp to it
  always_comb begin
    row_cl = ({1'b0, in_data.row} >= 3'(lcdseq_pkg::ROW_COUNT)) ?
             2'(lcdseq_pkg::ROW_COUNT - 1) : in_data.row;
    cursor_byte = lcdseq_pkg::LCD_SET_DDRAM |
                  ({2'b00, in_data.col} + lcdseq_pkg::row_offset(row_cl));
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  // leading zeros are skipped, the ones digit always prints
  assign skip_zero = !started_r && (rd_digit == 4'd0) && (idx_r != '0);
  assign last_take = out_valid && out_ready && out_data.last;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    started_nxt   = started_r;
    pend_byte_nxt = pend_byte_r;
    pend_data_nxt = pend_data_r;
    conv_start    = 1'b0;
    req           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (in_data.op)
            lcdseq_pkg::OP_CMD: begin
              pend_byte_nxt = in_data.value[7:0];
              pend_data_nxt = 1'b0;
              state_nxt     = ST_SEND;
            end
            lcdseq_pkg::OP_DATA: begin
              pend_byte_nxt = in_data.value[7:0];
              pend_data_nxt = 1'b1;
              state_nxt     = ST_SEND;
            end
            lcdseq_pkg::OP_NUM: begin
              conv_start  = 1'b1;
              idx_nxt     = IDX_W'(MAX_DIGITS - 1);
              started_nxt = 1'b0;
              state_nxt   = ST_CONV;
            end
            default: begin
              pend_byte_nxt = cursor_byte;
              pend_data_nxt = 1'b0;
              state_nxt     = ST_SEND;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (!conv_busy) begin
          // a number cut to its low digits prints every one of them
          started_nxt = conv_ovf;
          state_nxt   = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (skip_zero) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          req.valid     = 1'b1;
          req.lcd_byte  = lcdseq_pkg::ASCII_ZERO | {4'b0000, rd_digit};
          req.is_data   = 1'b1;
          req.last_byte = (idx_r == '0);
          if (req_ready) begin
            started_nxt = 1'b1;
            if (idx_r == '0) begin
              state_nxt = ST_WAIT;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      ST_SEND: begin
        req.valid     = 1'b1;
        req.lcd_byte  = pend_byte_r;
        req.is_data   = pend_data_r;
        req.last_byte = 1'b1;
        if (req_ready) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // the sender drops busy once the sixth beat of the last byte is taken
        if (req_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    pend_data_r <= pend_data_nxt;
  end

  lcdseq_digit_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (conv_start),
    .value_i    (in_data.value),
    .busy_o     (conv_busy),
    .ovf_o      (conv_ovf),
    .rd_idx_i   (idx_r),
    .rd_digit_o (rd_digit)
  );

  lcdseq_nibble_tx u_tx (
    .clk         (clk),
    .rst_n       (rst_n),
    .masks_i     (masks_r),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  `ASSERT_IMPLY(a_accept_only_when_quiet, clk, rst_n, in_valid && in_ready, !out_valid)
  `ASSERT_IMPLY(a_digits_after_conv, clk, rst_n, state_r == ST_DIGITS, !conv_busy)
  `ASSERT_NEXT(a_last_beat_then_wait, clk, rst_n, last_take, state_r == ST_WAIT)

endmodule
